>>> design/uq_alu_pkg.sv
// ----------------------------------------------------------------------------
// uq_alu_pkg
// Shared opcodes, widths and pipeline types for the unsigned 64.64 ALU.
// ----------------------------------------------------------------------------
`default_nettype none
package uq_alu_pkg;
   localparam int HalfW = 64;
   localparam int WordW = 128;
   localparam int FuncW = 3;
   localparam int ShW   = 8;

   localparam logic [FuncW-1:0] FUNC_ADD = 3'd0;
   localparam logic [FuncW-1:0] FUNC_SUB = 3'd1;
   localparam logic [FuncW-1:0] FUNC_MUL = 3'd2;
   localparam logic [FuncW-1:0] FUNC_SHF = 3'd3;
   localparam logic [FuncW-1:0] FUNC_CMP = 3'd4;

   // 32x32 partial product grid: index 4*i+j for a word i, b word j
   typedef logic [63:0] pp_type [16];

   typedef struct packed {
      logic [WordW-1:0] res;
      logic             flag;
      logic             is_mul;
   } early_type;
endpackage
`default_nettype wire

>>> design/uq_alu_mul.sv
// ----------------------------------------------------------------------------
// uq_alu_mul
// Three-stage stallable multiplier core: partial products, two partial sums,
// final add and shifted select. Also carries the non-multiply result alongside.
// ----------------------------------------------------------------------------
`default_nettype none
module uq_alu_mul
   import uq_alu_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   input  wire logic             in_valid,
   input  wire logic [WordW-1:0] a,
   input  wire logic [WordW-1:0] b,
   input  wire early_type        early,
   output logic                  out_valid,
   output logic [WordW-1:0]      res,
   output logic                  flag
);
   pp_type pp_ff, pp_in;
   early_type e1_ff, e2_ff, e3_ff;
   logic v1_ff, v2_ff, v3_ff;
   logic [255:0] slo_ff, slo_in, shi_ff, shi_in;
   logic [191:0] s_sum;
   logic [WordW-1:0] r_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            pp_in[4*i+j] = a[32*i +: 32] * b[32*j +: 32];
         end
      end
   end

   // two sums of eight shifted products each; shifts are wiring
   always_comb begin
      slo_in = '0;
      shi_in = '0;
      for (int k = 0; k < 8; k++) begin
         slo_in = slo_in + ({192'd0, pp_ff[k]} << (32 * ((k / 4) + (k % 4))));
      end
      for (int k = 8; k < 16; k++) begin
         shi_in = shi_in + ({192'd0, pp_ff[k]} << (32 * ((k / 4) + (k % 4))));
      end
   end

   // only bits up to 191 reach the result; higher carries are dropped
   assign s_sum = slo_ff[191:0] + shi_ff[191:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pp_ff  <= pp_in;
         e1_ff  <= early;
         slo_ff <= slo_in;
         shi_ff <= shi_in;
         e2_ff  <= e1_ff;
         r_ff   <= s_sum[HalfW +: WordW];
         e3_ff  <= e2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign res       = e3_ff.is_mul ? r_ff : e3_ff.res;
   assign flag      = e3_ff.flag;
endmodule
`default_nettype wire

>>> design/unsigned_q64_64_alu_top.sv
// ----------------------------------------------------------------------------
// unsigned_q64_64_alu_top
// Unsigned 64.64 fixed-point ALU: add, sub, multiply, shift, compare.
// ----------------------------------------------------------------------------
// channel | dir | handshake        | payload
// req     | in  | req_valid/stall  | func, a/b halves, shift_amount
// rsp     | out | rsp_valid/stall  | sum halves, compare_flag
//
// One beat per cycle while no output beat is stalled.
// The multiplier's product, partial-sum and final-add stages plus the
// output register set the depth.
// Reset clears all valid bits. The whole pipe holds while an output beat
// is stalled; an empty output slot lets the pipe advance.
`default_nettype none
module unsigned_q64_64_alu_top
   import uq_alu_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [FuncW-1:0] req_func,
   input  wire logic [HalfW-1:0] req_a_integer,
   input  wire logic [HalfW-1:0] req_a_fraction,
   input  wire logic [HalfW-1:0] req_b_integer,
   input  wire logic [HalfW-1:0] req_b_fraction,
   input  wire logic [ShW-1:0]   req_shift_amount,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [HalfW-1:0]      rsp_sum_integer,
   output logic [HalfW-1:0]      rsp_sum_fraction,
   output logic                  rsp_compare_flag
);
   logic [WordW-1:0] a, b, shl, shr, res;
   logic [ShW-1:0] mag;
   early_type early;
   logic adv, v, flag, vo_ff;
   logic [WordW-1:0] ro_ff;
   logic fo_ff;

   assign a   = {req_a_integer, req_a_fraction};
   assign b   = {req_b_integer, req_b_fraction};
   assign mag = req_shift_amount[ShW-1] ? (~req_shift_amount + 8'd1) : req_shift_amount;
   assign shl = (mag[7]) ? '0 : (a << mag[6:0]);
   assign shr = (mag[7]) ? '0 : (a >> mag[6:0]);

   always_comb begin
      early = '0;
      case (req_func)
         FUNC_ADD: early.res = a + b;
         FUNC_SUB: early.res = a - b;
         FUNC_MUL: early.is_mul = 1'b1;
         FUNC_SHF: early.res = req_shift_amount[ShW-1] ? shr : shl;
         FUNC_CMP: early.flag = (req_a_integer >= req_b_integer);
         default:  early = '0;
      endcase
   end

   assign adv       = !vo_ff || !rsp_stall;
   assign req_stall = !adv;

   uq_alu_mul u_mul (
      .clock, .reset, .adv,
      .in_valid (req_valid),
      .a, .b, .early,
      .out_valid (v),
      .res, .flag
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (adv) begin
         vo_ff <= v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ro_ff <= res;
         fo_ff <= flag;
      end
   end

   assign rsp_valid        = vo_ff;
   assign rsp_sum_integer  = ro_ff[WordW-1:HalfW];
   assign rsp_sum_fraction = ro_ff[HalfW-1:0];
   assign rsp_compare_flag = fo_ff;
endmodule
`default_nettype wire

>>> design/uq_alu_chk.sv
// ----------------------------------------------------------------------------
// uq_alu_chk
// Port-level checks for the ALU top, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none
module uq_alu_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [63:0] rsp_sum_integer,
   input wire logic [63:0] rsp_sum_fraction,
   input wire logic        rsp_compare_flag
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sum_integer))
      else $error("stalled beat changed");
   a_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_compare_flag |-> rsp_sum_integer == 64'd0 && rsp_sum_fraction == 64'd0)
      else $error("compare with nonzero sum");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");
   a_rst: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("valid after reset");
endmodule

bind unsigned_q64_64_alu_top uq_alu_chk u_chk (
   .clock, .reset, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_sum_integer, .rsp_sum_fraction, .rsp_compare_flag
);
`default_nettype wire
